>>> rtl/id3x_pkg.sv
// Package for the ID3v2 title/artist extractor: payload words, parse phases,
// result kinds, status codes and register indexes. No dependencies.
package id3x_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  text_byte;
        logic        text_end;
        logic [28:0] data_start;
        logic [1:0]  status;
        logic        done_res;
    } t_out_word;

    typedef enum logic [2:0] {
        PH_HEAD = 3'd0,
        PH_FHDR = 3'd1,
        PH_ENC  = 3'd2,
        PH_COPY = 3'd3,
        PH_IDLE = 3'd4
    } t_phase;

    localparam logic [1:0] KIND_TITLE  = 2'd0;
    localparam logic [1:0] KIND_ARTIST = 2'd1;
    localparam logic [1:0] KIND_REPORT = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_TAG  = 2'd1;
    localparam logic [1:0] ST_OLD_VER = 2'd2;
    localparam logic [1:0] ST_SHORT   = 2'd3;

    localparam logic REG_TITLE_MAX  = 1'b0;
    localparam logic REG_ARTIST_MAX = 1'b1;

    localparam logic [7:0] MAX_RESET = 8'd40;

    localparam logic [23:0] ID_ID3  = 24'h494433;
    localparam logic [23:0] ID_TT2  = 24'h545432;
    localparam logic [31:0] ID_TIT2 = 32'h54495432;
    localparam logic [23:0] ID_TP1  = 24'h545031;
    localparam logic [31:0] ID_TPE1 = 32'h54504531;

    localparam logic [31:0] HDR_LEN = 32'd10;

    // result buffer: room for two results per accepted byte plus slack
    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_AW    = 2;

endpackage

>>> rtl/id3v2_title_artist_extractor_unit.sv
// Top level of the ID3v2 title/artist extractor: header check, frame walk,
// text copy and a small result buffer. Depends on id3x_pkg.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------------
//  input    | i_in_valid / o_in_ready     | i_in_word  (byte, last flag)
//  output   | o_out_valid / i_out_ready   | o_out_word (kind, text, report)
//  config   | psel/penable/pwrite, pready | paddr, pwdata, prdata
//
// One input word per cycle while o_in_ready is high. Each byte is parsed in the
// cycle it is accepted and its results (none or one, up to two on the last byte)
// go to a 4-word buffer. o_in_ready is high while two or more slots are free.
// Reset is synchronous, active low; it clears parse state and restores both
// max registers to 40. After a word with last_byte the parser starts over.
module id3v2_title_artist_extractor_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  id3x_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output id3x_pkg::t_out_word  o_out_word,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import id3x_pkg::*;

    // config registers
    logic [7:0] r_title_max, r_artist_max;
    logic       cfg_wr;

    // parse state
    logic [31:0] r_pos, n_pos;
    logic [28:0] r_tag, n_tag;
    t_phase      r_phase, n_phase;
    logic [31:0] r_fs, n_fs;
    logic [31:0] r_flen, n_flen;
    logic [31:0] r_ident, n_ident;
    logic [7:0]  r_copy_left, n_copy_left;
    logic        r_field, n_field;
    logic [7:0]  r_major, n_major;
    logic [1:0]  r_hdr_st, n_hdr_st;

    // result buffer
    t_out_word          r_buf [OBUF_DEPTH];
    logic [OBUF_AW-1:0] r_wr, r_rd;
    logic [OBUF_AW:0]   r_cnt;

    logic        in_acc, pop, last;
    logic [7:0]  b;
    logic [31:0] off, fs_next, flen_m1;
    logic [32:0] fs_sum;
    logic        is_title, is_artist;
    logic [7:0]  lim, lim_c, cl;
    logic        v_text, v_hdr, v_fin, fin_short;
    logic [7:0]  t_byte;
    logic        t_end;
    logic [28:0] fin_ds;
    logic [1:0]  fin_st;
    t_out_word   w_text, w_hdr, w_fin, e0;
    logic        push0, push1;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_ARTIST_MAX) ? {24'd0, r_artist_max}
                                                 : {24'd0, r_title_max};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_title_max  <= MAX_RESET;
            r_artist_max <= MAX_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_TITLE_MAX) r_title_max <= pwdata[7:0];
            else                           r_artist_max <= pwdata[7:0];
        end
    end

    assign o_in_ready  = (r_cnt <= (OBUF_AW+1)'(OBUF_DEPTH - 2));
    assign in_acc      = i_in_valid & o_in_ready;
    assign o_out_valid = (r_cnt != '0);
    assign pop         = o_out_valid & i_out_ready;
    assign o_out_word  = r_buf[r_rd];

    assign b    = i_in_word.in_byte;
    assign last = i_in_word.last_byte;

    // frame header bookkeeping
    assign off       = r_pos - r_fs;
    assign fs_sum    = {1'b0, r_fs} + {1'b0, HDR_LEN} + {1'b0, r_flen};
    assign fs_next   = fs_sum[32] ? '1 : fs_sum[31:0];
    assign is_title  = (r_ident[31:8] == ID_TT2) || (r_ident == ID_TIT2);
    assign is_artist = (r_ident[31:8] == ID_TP1) || (r_ident == ID_TPE1);
    assign lim       = is_title ? r_title_max : r_artist_max;
    assign lim_c     = (lim == 8'd0) ? 8'd0 : lim - 8'd1;
    assign flen_m1   = r_flen - 32'd1;
    assign cl        = (flen_m1 < {24'd0, lim_c}) ? flen_m1[7:0] : lim_c;

    always_comb begin
        n_pos       = r_pos;
        n_tag       = r_tag;
        n_phase     = r_phase;
        n_fs        = r_fs;
        n_flen      = r_flen;
        n_ident     = r_ident;
        n_copy_left = r_copy_left;
        n_field     = r_field;
        n_major     = r_major;
        n_hdr_st    = r_hdr_st;
        v_text      = 1'b0;
        v_hdr       = 1'b0;
        v_fin       = 1'b0;
        fin_short   = 1'b0;
        t_byte      = 8'd0;
        t_end       = 1'b0;
        fin_ds      = r_tag;
        fin_st      = r_hdr_st;
        if (in_acc) begin
            case (r_phase)
                PH_HEAD: begin
                    if (r_pos < 32'd3) n_ident = {r_ident[23:0], b};
                    if (r_pos == 32'd3) n_major = b;
                    // size bytes keep their top bits
                    if (r_pos >= 32'd6) n_tag = {r_tag[21:0], 7'd0} | {21'd0, b};
                    if (r_pos == 32'd9) begin
                        v_hdr = 1'b1;
                        if (r_ident[23:0] != ID_ID3) begin
                            n_hdr_st = ST_NO_TAG;
                            n_tag    = '0;
                            n_phase  = PH_IDLE;
                        end else if (r_major < 8'd3) begin
                            n_hdr_st = ST_OLD_VER;
                            n_phase  = PH_IDLE;
                        end else begin
                            n_hdr_st = ST_OK;
                            n_fs     = HDR_LEN;
                            n_phase  = (HDR_LEN < {3'd0, n_tag}) ? PH_FHDR : PH_IDLE;
                        end
                        n_ident = '0;
                    end
                end
                PH_FHDR: begin
                    // off wraps high while skipping the rest of a cut-short frame
                    if (off < 32'd4)      n_ident = {r_ident[23:0], b};
                    else if (off < 32'd8) n_flen  = {r_flen[23:0], b};
                    if (off == 32'd9) begin
                        n_copy_left = 8'd0;
                        if (is_title || is_artist) begin
                            n_field = ~is_title;
                            if (r_flen != 32'd0) n_copy_left = cl;
                        end
                        n_fs = fs_next;
                        if (r_flen == 32'd0)
                            n_phase = (fs_next < {3'd0, r_tag}) ? PH_FHDR : PH_IDLE;
                        else
                            n_phase = PH_ENC;
                    end
                end
                PH_ENC: begin
                    if (r_copy_left != 8'd0) n_phase = PH_COPY;
                    else n_phase = (r_fs < {3'd0, r_tag}) ? PH_FHDR : PH_IDLE;
                end
                PH_COPY: begin
                    v_text = 1'b1;
                    if (b == 8'd0) begin
                        t_end       = 1'b1;
                        n_copy_left = 8'd0;
                    end else begin
                        t_byte      = b;
                        t_end       = (r_copy_left <= 8'd1) | last;
                        n_copy_left = r_copy_left - 8'd1;
                    end
                    if (n_copy_left == 8'd0)
                        n_phase = (r_fs < {3'd0, r_tag}) ? PH_FHDR : PH_IDLE;
                end
                default: ;
            endcase
            n_pos     = r_pos + 32'd1;
            v_fin     = last & ~v_hdr;
            fin_short = (r_phase == PH_HEAD);
            fin_ds    = n_tag;
            fin_st    = n_hdr_st;
            if (last) begin
                n_pos       = '0;
                n_tag       = '0;
                n_phase     = PH_HEAD;
                n_fs        = HDR_LEN;
                n_flen      = '0;
                n_ident     = '0;
                n_copy_left = 8'd0;
                n_field     = 1'b0;
                n_major     = 8'd0;
                n_hdr_st    = ST_OK;
            end
        end
    end

    always_comb begin
        w_text = '{out_kind: r_field ? KIND_ARTIST : KIND_TITLE, text_byte: t_byte,
                   text_end: t_end, data_start: '0, status: ST_OK, done_res: 1'b0};
        w_hdr  = '{out_kind: KIND_REPORT, text_byte: 8'd0, text_end: 1'b0,
                   data_start: fin_ds, status: fin_st, done_res: last};
        w_fin  = '{out_kind: KIND_REPORT, text_byte: 8'd0, text_end: 1'b0,
                   data_start: fin_short ? 29'd0 : fin_ds,
                   status: fin_short ? ST_SHORT : fin_st, done_res: 1'b1};
        if (v_text)     e0 = w_text;
        else if (v_hdr) e0 = w_hdr;
        else            e0 = w_fin;
        push0 = v_text | v_hdr | v_fin;
        push1 = v_text & v_fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_tag       <= '0;
            r_phase     <= PH_HEAD;
            r_fs        <= HDR_LEN;
            r_flen      <= '0;
            r_ident     <= '0;
            r_copy_left <= 8'd0;
            r_field     <= 1'b0;
            r_major     <= 8'd0;
            r_hdr_st    <= ST_OK;
            r_wr        <= '0;
            r_rd        <= '0;
            r_cnt       <= '0;
        end else begin
            r_pos       <= n_pos;
            r_tag       <= n_tag;
            r_phase     <= n_phase;
            r_fs        <= n_fs;
            r_flen      <= n_flen;
            r_ident     <= n_ident;
            r_copy_left <= n_copy_left;
            r_field     <= n_field;
            r_major     <= n_major;
            r_hdr_st    <= n_hdr_st;
            r_wr        <= r_wr + OBUF_AW'(push0) + OBUF_AW'(push1);
            if (pop) r_rd <= r_rd + OBUF_AW'(1);
            r_cnt       <= r_cnt + (OBUF_AW+1)'(push0) + (OBUF_AW+1)'(push1)
                           - (OBUF_AW+1)'(pop);
        end
    end

    // buffer payload, no reset
    always_ff @(posedge i_clk) begin
        if (push0) r_buf[r_wr] <= e0;
        if (push1) r_buf[r_wr + OBUF_AW'(1)] <= w_fin;
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (OBUF_AW+1)'(OBUF_DEPTH))
        else $error("result buffer overfilled");

    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.last_byte) |=> (r_phase == PH_HEAD && r_pos == 32'd0))
        else $error("parser did not restart after last word");

    a_copy_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_COPY) |-> (r_copy_left != 8'd0))
        else $error("copy phase with nothing left to copy");

    // frame start sits below the tag size here, so the sum cannot wrap
    a_fhdr_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FHDR) |-> (r_pos <= r_fs + 32'd9))
        else $error("byte position ran past frame header");

    a_kind_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.out_kind <= KIND_REPORT))
        else $error("bad result kind");
`endif

endmodule
